[rtl/tln_pkg.sv]
// ----------------------------------------------------------------------------
// tln_pkg
// Shared types and constants of the text line detab normalizer.
// ----------------------------------------------------------------------------
package tln_pkg;

    // Character codes
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_EOF      = 8'h1A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_CTRL_MAX = 8'h1F;

    // Tab width field and its clamp limits
    localparam int unsigned TW_BITS = 5;
    localparam logic [TW_BITS-1:0] TW_MIN = 5'd1;
    localparam logic [TW_BITS-1:0] TW_MAX = 5'd16;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHAR_MASK    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAB_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEEP_CONTROL = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_CLOSE,
        ST_END,
        ST_DIV,
        ST_SPACE
    } tln_state_t;

    // Remainder unit result
    typedef struct packed {
        logic               done;
        logic [TW_BITS-1:0] rem;
    } tln_div_res_t;

endpackage

[rtl/tln_tab_rem.sv]
// ----------------------------------------------------------------------------
// tln_tab_rem
// Iterative remainder unit: column modulo tab width, one bit per cycle.
// ----------------------------------------------------------------------------
module tln_tab_rem #(
    parameter int unsigned CW = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [CW-1:0]               dividend,
    input  logic [tln_pkg::TW_BITS-1:0] divisor,
    output tln_pkg::tln_div_res_t       res
);
    import tln_pkg::*;

    localparam int unsigned IW = (CW > 1) ? $clog2(CW) : 1;

    logic               active_reg, active_next;
    logic               done_reg, done_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [TW_BITS-1:0] rem_reg, rem_next;
    logic [TW_BITS-1:0] trial;

    // Shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg[TW_BITS-2:0], dividend[idx_reg]};

    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        if (start)
        begin
            active_next = 1'b1;
            idx_next    = IW'(CW - 1);
            rem_next    = '0;
        end
        else if (active_reg)
        begin
            rem_next = (trial >= divisor) ? (trial - divisor) : trial;
            if (idx_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

`ifndef NO_ASSERTIONS
    // Remainder always below the divisor once a run completes
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < divisor))
        else $error("tab remainder not below tab width");

    // Done only follows an active run
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |-> active_reg)
        else $error("remainder done without an active run");

    // No restart while a run is in progress
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !start)
        else $error("remainder unit restarted while busy");
`endif

endmodule

[rtl/text_line_detab_normalizer.sv]
// ----------------------------------------------------------------------------
// text_line_detab_normalizer
// Turns a raw file byte stream into normalized line characters with marks.
// ----------------------------------------------------------------------------
// One input byte is taken while the sequencer is idle, then the block is busy
// until all results of that byte are loaded into the output register. A
// printable or control byte, CR and an end mark each load one result, LF
// loads none, and a split at the line limit adds a line end. A tab first runs
// the bit-serial remainder unit over the CW = $clog2(LINE_LIMIT) column bits
// to find the column modulo the tab width, then loads its spaces, one per
// cycle while the output does not stall. After the file end every byte is
// taken and dropped.
// ----------------------------------------------------------------------------
module text_line_detab_normalizer #(
    parameter int unsigned LINE_LIMIT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input bytes
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]                       s_axis_tuser,  // [0] input_end, [1] read_error
    // Results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] out_char
    output logic [2:0]                       m_axis_tuser,  // [0] line_end, [1] file_end,
                                                            // [2] failed
    output logic                             m_axis_tlast,  // last
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tln_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);
    import tln_pkg::*;

    localparam int unsigned CW = $clog2(LINE_LIMIT);
    localparam logic [CW-1:0] COL_MAX = CW'(LINE_LIMIT - 1);

    // Configuration registers
    logic [7:0]         char_mask_reg;
    logic [TW_BITS-1:0] tab_width_reg;
    logic               keep_control_reg;

    // Sequencer and line state
    tln_state_t         state_reg, state_next;
    logic [CW-1:0]      column_reg, column_next;
    logic               finished_reg, finished_next;
    logic               no_line_reg, no_line_next;
    logic [7:0]         char_reg, char_next;
    logic               fail_reg, fail_next;
    logic [TW_BITS-1:0] cnt_reg, cnt_next;

    // Output register
    logic               m_valid_reg;
    logic [7:0]         m_char_reg;
    logic               m_le_reg, m_fe_reg, m_fl_reg, m_last_reg;

    // Result being emitted this cycle
    logic               emit;
    logic [7:0]         e_char;
    logic               e_le, e_fe, e_fl, e_last;
    logic               div_start;

    // Decode helpers
    logic               in_acc;
    logic               slot_free;
    logic [7:0]         masked;
    logic               is_print;
    logic [CW-1:0]      col_plus;
    logic               col_hit;
    logic [TW_BITS-1:0] tw_eff;
    tln_div_res_t       div_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !m_valid_reg || m_axis_tready;
    assign masked        = s_axis_tdata & char_mask_reg;
    assign is_print      = masked > CH_CTRL_MAX;
    assign col_plus      = column_reg + 1'b1;
    assign col_hit       = (col_plus == COL_MAX);
    assign cfg_ready     = 1'b1;

    // Tab width clamped to its legal range
    always_comb
    begin
        if (tab_width_reg < TW_MIN)
            tw_eff = TW_MIN;
        else if (tab_width_reg > TW_MAX)
            tw_eff = TW_MAX;
        else
            tw_eff = tab_width_reg;
    end

    tln_tab_rem #(
        .CW (CW)
    ) u_tab_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (column_reg),
        .divisor  (tw_eff),
        .res      (div_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !finished_reg)
                begin
                    if (s_axis_tuser[1] || s_axis_tuser[0])
                        state_next = ST_END;
                    else if (is_print)
                        state_next = ST_CHAR;
                    else if (s_axis_tdata == CH_CR)
                        state_next = ST_CLOSE;
                    else if (s_axis_tdata == CH_LF)
                        state_next = ST_IDLE;
                    else if (s_axis_tdata == CH_TAB)
                        state_next = ST_DIV;
                    else if (s_axis_tdata == CH_EOF)
                        state_next = ST_END;
                    else
                        state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (slot_free)
                    state_next = col_hit ? ST_CLOSE : ST_IDLE;
            end
            ST_CLOSE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_END:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_res.done)
                    state_next = ST_SPACE;
            end
            ST_SPACE:
            begin
                if (slot_free && (col_hit || cnt_reg == TW_MIN))
                    state_next = col_hit ? ST_CLOSE : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Results and datapath updates
    always_comb
    begin
        emit          = 1'b0;
        e_char        = '0;
        e_le          = 1'b0;
        e_fe          = 1'b0;
        e_fl          = 1'b0;
        e_last        = 1'b0;
        div_start     = 1'b0;
        column_next   = column_reg;
        finished_next = finished_reg;
        no_line_next  = no_line_reg;
        char_next     = char_reg;
        fail_next     = fail_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && !finished_reg)
                begin
                    fail_next = s_axis_tuser[1];
                    if (is_print)
                        char_next = masked;
                    else if (keep_control_reg)
                        char_next = s_axis_tdata;
                    else
                        char_next = CH_QUESTION;
                    div_start = !s_axis_tuser[1] && !s_axis_tuser[0] && !is_print
                                && (s_axis_tdata == CH_TAB);
                end
            end
            ST_CHAR:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    e_char      = char_reg;
                    e_last      = !col_hit;
                    column_next = col_plus;
                end
            end
            ST_CLOSE:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    e_le         = 1'b1;
                    e_last       = 1'b1;
                    column_next  = '0;
                    no_line_next = 1'b0;
                end
            end
            ST_END:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    e_le          = (column_reg != '0) || no_line_reg;
                    e_fe          = 1'b1;
                    e_fl          = fail_reg;
                    e_last        = 1'b1;
                    column_next   = '0;
                    no_line_next  = 1'b0;
                    finished_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_res.done)
                    cnt_next = tw_eff - div_res.rem;
            end
            ST_SPACE:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    e_char      = CH_SPACE;
                    e_last      = !col_hit && (cnt_reg == TW_MIN);
                    column_next = col_plus;
                    cnt_next    = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            column_reg       <= '0;
            finished_reg     <= 1'b0;
            no_line_reg      <= 1'b1;
            m_valid_reg      <= 1'b0;
            char_mask_reg    <= 8'hFF;
            tab_width_reg    <= 5'd8;
            keep_control_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            column_reg   <= column_next;
            finished_reg <= finished_next;
            no_line_reg  <= no_line_next;
            if (emit)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CHAR_MASK:    char_mask_reg    <= cfg_data;
                    CFG_TAB_WIDTH:    tab_width_reg    <= cfg_data[TW_BITS-1:0];
                    CFG_KEEP_CONTROL: keep_control_reg <= cfg_data[0];
                    default:          keep_control_reg <= keep_control_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        fail_reg <= fail_next;
        cnt_reg  <= cnt_next;
        if (emit)
        begin
            m_char_reg <= e_char;
            m_le_reg   <= e_le;
            m_fe_reg   <= e_fe;
            m_fl_reg   <= e_fl;
            m_last_reg <= e_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_char_reg;
    assign m_axis_tuser  = {m_fl_reg, m_fe_reg, m_le_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Column never passes the split point; it sits there only until the close
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_MAX)
        else $error("column passed the line limit");

    // Once the file is finished it stays finished
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag dropped");

    // A file end result is always the last of its byte
    a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("file end result without last");

    // Failed is only reported on the file end result
    a_fail_fe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1])
        else $error("failed without file end");

    // A result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> slot_free)
        else $error("result overwritten in output register");
`endif

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the text line detab normalizer.
// ----------------------------------------------------------------------------
// Bytes are pushed through the input stream one item at a time. Each accepted
// byte runs through a line predictor that keeps its own column, end-of-file
// and first-line state, and the characters and marks it predicts are queued.
// Every result item taken from the output stream is checked field by field
// against the oldest queued entry. Both streams idle at random. Directed tests
// cover printable bytes, control codes, masking, tab stops and a tab at the
// line limit. Random phases follow with fresh settings. The run closes with
// one randomly chosen file end and a burst of bytes that must be ignored.
// ----------------------------------------------------------------------------
module tb_top;
    import tln_pkg::*;

    localparam int unsigned LINE_LIMIT     = 256;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned END_WAIT       = 40;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned IDLE_PCT       = 32;
    localparam int unsigned RANDOM_PHASES  = 5;
    localparam int unsigned PHASE_ITEMS    = 60;

    // Input tuser marks
    localparam logic [1:0] MARK_NONE       = 2'b00;
    localparam logic [1:0] MARK_INPUT_END  = 2'b01;
    localparam logic [1:0] MARK_READ_ERROR = 2'b10;
    localparam logic [1:0] MARK_BOTH       = 2'b11;

    // Register index with no register behind it
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    // One predicted result item
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       file_end;
        logic       failed;
        logic       lst;
    } line_item_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [7:0]              s_axis_tdata;
    logic [1:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [7:0]              m_axis_tdata;
    logic [2:0]              m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [7:0]              cfg_data;

    // Predictor state and its copy of the settings
    line_item_t          line_q[$];
    int unsigned         col;
    bit                  file_done;
    bit                  no_line;
    logic [7:0]          mask_reg;
    logic [TW_BITS-1:0]  tw_reg;
    bit                  keep_reg;

    int          errors;
    int unsigned send_idle_pct;
    int unsigned ready_idle_pct;
    int unsigned quiet_cycles;

    text_line_detab_normalizer #(
        .LINE_LIMIT(LINE_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Line predictor
    // ------------------------------------------------------------------------
    function automatic void push_result(logic [7:0] ch, logic le, logic fe, logic fl);
        line_item_t r;
        r.ch       = ch;
        r.line_end = le;
        r.file_end = fe;
        r.failed   = fl;
        r.lst      = 1'b0;
        line_q.push_back(r);
    endfunction

    function automatic void close_line();
        push_result(8'h00, 1'b1, 1'b0, 1'b0);
        col     = 0;
        no_line = 1'b0;
    endfunction

    function automatic void add_char(logic [7:0] ch);
        push_result(ch, 1'b0, 1'b0, 1'b0);
        col++;
        if (col >= LINE_LIMIT - 1)
            close_line();
    endfunction

    // Pending line is closed if it holds characters or no line went out yet
    function automatic void finish_file(logic fl);
        if (col > 0 || no_line)
        begin
            push_result(8'h00, 1'b1, 1'b1, fl);
            col     = 0;
            no_line = 1'b0;
        end
        else
            push_result(8'h00, 1'b0, 1'b1, fl);
        file_done = 1'b1;
    endfunction

    // Tab width with zero and oversize values clamped
    function automatic int unsigned tab_stop_width();
        int unsigned w;
        w = 32'(tw_reg);
        if (w < 32'(TW_MIN))
            w = 32'(TW_MIN);
        if (w > 32'(TW_MAX))
            w = 32'(TW_MAX);
        return w;
    endfunction

    function automatic void predict_line_chars(logic [7:0] b, logic [1:0] marks);
        int unsigned n0;
        int unsigned w;
        int unsigned cnt;
        int unsigned room;
        logic [7:0]  m;
        line_item_t  r;
        n0 = line_q.size();
        if (file_done)
            return;
        if (marks[1])
            finish_file(1'b1);
        else if (marks[0])
            finish_file(1'b0);
        else
        begin
            m = b & mask_reg;
            if (m > CH_CTRL_MAX)
                add_char(m);
            else if (b == CH_CR)
                close_line();
            else if (b == CH_LF)
                ;
            else if (b == CH_TAB)
            begin
                w    = tab_stop_width();
                cnt  = w - (col % w);
                room = LINE_LIMIT - 1 - col;
                if (cnt > room)
                    cnt = room;
                repeat (cnt)
                begin
                    push_result(CH_SPACE, 1'b0, 1'b0, 1'b0);
                    col++;
                end
                if (col >= LINE_LIMIT - 1)
                    close_line();
            end
            else if (b == CH_EOF)
                finish_file(1'b0);
            else
                add_char(keep_reg ? b : CH_QUESTION);
        end
        // Mark the final result of this byte
        if (line_q.size() > n0)
        begin
            r     = line_q.pop_back();
            r.lst = 1'b1;
            line_q.push_back(r);
        end
    endfunction

    function automatic bit is_special(logic [7:0] b);
        return b == CH_TAB || b == CH_CR || b == CH_LF || b == CH_EOF;
    endfunction

    // Any byte that adds exactly one character
    function automatic logic [7:0] pick_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_special(b));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(logic [7:0] b, logic [1:0] marks);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= marks;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_line_chars(b, marks);
    endtask

    // Stop sending and let every expected result come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (line_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CHAR_MASK:    mask_reg = val;
            CFG_TAB_WIDTH:    tw_reg   = val[TW_BITS-1:0];
            CFG_KEEP_CONTROL: keep_reg = val[0];
            default:          ;
        endcase
    endtask

    task automatic set_config(logic [7:0] m, logic [7:0] tw, logic [7:0] k);
        drain_results();
        write_reg(CFG_CHAR_MASK, m);
        write_reg(CFG_TAB_WIDTH, tw);
        write_reg(CFG_KEEP_CONTROL, k);
        cfg_valid <= 1'b0;
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= ready_idle_pct);

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        line_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got char %0h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                want = line_q.pop_front();
                check_field("out_char", want.ch, m_axis_tdata);
                check_field("line_end", 8'(want.line_end), 8'(m_axis_tuser[0]));
                check_field("file_end", 8'(want.file_end), 8'(m_axis_tuser[1]));
                check_field("failed", 8'(want.failed), 8'(m_axis_tuser[2]));
                check_field("last", 8'(want.lst), 8'(m_axis_tlast));
            end
        end
    end

    // Watchdog on cycles with no item moving anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_line_detab_normalizer regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Printable bytes, controls replaced by '?', LF dropped, tab, CR
    task automatic test_printable_and_controls();
        set_config(8'hFF, 8'd8, 8'd0);
        send_item(8'h41, MARK_NONE);
        send_item(CH_SPACE, MARK_NONE);
        send_item(8'h7E, MARK_NONE);
        send_item(8'hFF, MARK_NONE);
        send_item(8'h80, MARK_NONE);
        send_item(8'h00, MARK_NONE);
        send_item(CH_CTRL_MAX, MARK_NONE);
        send_item(CH_LF, MARK_NONE);
        send_item(8'h7F, MARK_NONE);
        send_item(CH_TAB, MARK_NONE);
        send_item(CH_CR, MARK_NONE);
    endtask

    // Mask hides bits before the printable test; codes decided on the raw byte
    task automatic test_mask_and_keep();
        set_config(8'h7F, 8'd5, 8'd1);
        send_item(8'hC1, MARK_NONE);
        send_item(8'h8D, MARK_NONE);
        send_item(8'h9A, MARK_NONE);
        send_item(8'h89, MARK_NONE);
        send_item(8'h00, MARK_NONE);
        send_item(CH_TAB, MARK_NONE);
        send_item(CH_CR, MARK_NONE);
        // zero mask, zero tab width
        set_config(8'h00, 8'd0, 8'd0);
        send_item(8'h41, MARK_NONE);
        send_item(CH_TAB, MARK_NONE);
        send_item(8'h8A, MARK_NONE);
        send_item(CH_CR, MARK_NONE);
    endtask

    // Oversize tab width clamps to 16; the sixteenth tab hits the line limit
    task automatic test_tab_at_limit();
        set_config(8'hFF, 8'd31, 8'd0);
        @(posedge clk);
        write_reg(CFG_UNUSED, 8'h00);
        cfg_valid <= 1'b0;
        repeat (16) send_item(CH_TAB, MARK_NONE);
    endtask

    // Tabs until near the limit, then chars or tabs until the line splits
    task automatic send_long_line();
        bit use_tabs;
        use_tabs = 1'($urandom_range(1));
        while (col < 230)
            send_item(CH_TAB, MARK_NONE);
        while (col != 0)
            send_item(use_tabs ? CH_TAB : pick_char(), MARK_NONE);
    endtask

    task automatic test_random_lines();
        logic [7:0]  m;
        logic [7:0]  tw;
        logic [7:0]  b;
        int unsigned r;
        int unsigned long_at;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(3))
                0:       m = 8'hFF;
                1:       m = 8'h7F;
                2:       m = 8'h00;
                default: m = 8'($urandom_range(255));
            endcase
            if (p == 0)
                tw = 8'd16;
            else if ($urandom_range(3) == 0)
                tw = 8'($urandom_range(255));
            else
                tw = 8'($urandom_range(16));
            set_config(m, tw, 8'($urandom_range(1)));
            // one phase with no idling on either side
            send_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
            ready_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            long_at = $urandom_range(PHASE_ITEMS - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == long_at && tab_stop_width() >= 8)
                    send_long_line();
                r = $urandom_range(99);
                if (r < 55)
                    b = pick_char();
                else if (r < 70)
                    b = CH_TAB;
                else if (r < 80)
                    b = CH_CR;
                else if (r < 87)
                    b = CH_LF;
                else
                begin
                    do
                        b = 8'($urandom_range(31));
                    while (is_special(b));
                end
                send_item(b, MARK_NONE);
            end
        end
        send_idle_pct  = IDLE_PCT;
        ready_idle_pct = IDLE_PCT;
    endtask

    // One file end, then bytes and marks that must all be ignored
    task automatic test_file_end();
        logic [1:0] marks;
        if ($urandom_range(1))
            send_item(CH_CR, MARK_NONE);
        else
            send_item(pick_char(), MARK_NONE);
        case ($urandom_range(3))
            0:       send_item(CH_EOF, MARK_NONE);
            1:       send_item(8'($urandom_range(255)), MARK_INPUT_END);
            2:       send_item(8'($urandom_range(255)), MARK_READ_ERROR);
            default: send_item(8'($urandom_range(255)), MARK_BOTH);
        endcase
        repeat (24)
        begin
            marks = 2'($urandom_range(3));
            send_item(8'($urandom_range(255)), marks);
        end
        send_item(CH_EOF, MARK_BOTH);
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tuser   = MARK_NONE;
        m_axis_tready  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_CHAR_MASK;
        cfg_data       = 8'h00;
        errors         = 0;
        quiet_cycles   = 0;
        send_idle_pct  = IDLE_PCT;
        ready_idle_pct = IDLE_PCT;
        mask_reg       = 8'hFF;
        tw_reg         = 5'd8;
        keep_reg       = 1'b0;
        col            = 0;
        file_done      = 1'b0;
        no_line        = 1'b1;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_printable_and_controls();
        test_mask_and_keep();
        test_tab_at_limit();
        test_random_lines();
        test_file_end();

        repeat (END_WAIT) @(posedge clk);
        if (errors == 0)
            $display("text_line_detab_normalizer regression: pass");
        else
            $display("text_line_detab_normalizer regression: fail");
        $finish;
    end

endmodule
